FILE: hdl/btil_pkg.sv
// Package for the binary trie insert/lookup core: sizes, node record type and
// the request bundle that drives the node memory.
// No dependencies.
package btil_pkg;

  // Pool and key sizes
  localparam int NODE_COUNT   = 1024;
  localparam int NODE_W       = $clog2(NODE_COUNT);
  localparam int FREE_W       = NODE_W + 1;
  localparam int MAX_KEY_BITS = 32;
  localparam int KEY_W        = 32;
  localparam int LEN_W        = 6;
  localparam int POS_W        = $clog2(KEY_W);

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Match modes
  localparam logic MODE_PREFIX = 1'b0;
  localparam logic MODE_EXACT  = 1'b1;

  // One trie node: end mark and the two child links (0 means no child)
  typedef struct packed {
    logic                         end_mark;
    logic [1:0][NODE_W-1:0]       links;
  } node_rec_t;

  localparam int REC_W = $bits(node_rec_t);

  // One access request to the node memory
  typedef struct packed {
    logic              we;
    logic              re;
    logic [NODE_W-1:0] addr;
    node_rec_t         wdata;
  } ram_req_t;

endpackage

FILE: hdl/btil_if.sv
// Channel interfaces of the binary trie core: request and response items
// with a valid/ready handshake.
// Depends on btil_pkg.
interface btil_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [btil_pkg::KEY_W-1:0]    key_bits;
  logic [btil_pkg::LEN_W-1:0]    key_length;

  modport source (output valid, req_type, key_bits, key_length, input ready);
  modport sink   (input valid, req_type, key_bits, key_length, output ready);
endinterface

interface btil_rsp_if;
  logic valid;
  logic ready;
  logic found;
  logic pool_full;

  modport source (output valid, found, pool_full, input ready);
  modport sink   (input valid, found, pool_full, output ready);
endinterface

FILE: hdl/binary_trie_insert_lookup_core.sv
// Top level of the binary trie insert/lookup core: match mode register, key
// walker and node pool memory.
// Depends on btil_pkg, btil_if, btil_node_ram and btil_walker.
//
// Usage:
//   req_i carries one item per key: req_type (insert or lookup), key_bits and
//   key_length (saturated to 32). rsp_o returns one item per request: found
//   for lookups, pool_full for inserts that ran out of nodes.
//   cfg_we_i/cfg_wdata_i write match_mode (0 prefix, 1 exact); write it only
//   while no request is in flight.
// Walk:
//   One item is walked at a time. For each key bit that follows an existing
//   node the walker does one node memory read; for each bit that allocates a
//   node it writes the parent link, then clears the node. Around these come
//   the accept, the end step and the result. The node memory has a single
//   port, so these accesses are made one after another.
// Reset:
//   The trie is empty, the free pointer is 1 and match_mode is prefix. No
//   memory clearing pass is needed: nodes are cleared when allocated.
// Stall:
//   A result waits in the output register; the next request is accepted
//   meanwhile, and its result waits in the walker until the register frees.
module binary_trie_insert_lookup_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  btil_req_if.sink   req_i,
  btil_rsp_if.source rsp_o
);
  import btil_pkg::*;

  logic      match_mode_q;
  ram_req_t  ram_req;
  node_rec_t ram_rdata;

  // Match mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_mode_q <= MODE_PREFIX;
    end else if (cfg_we_i) begin
      match_mode_q <= cfg_wdata_i;
    end
  end

  btil_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .match_mode_i (match_mode_q),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata)
  );

  btil_node_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (REC_W)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .re_i    (ram_req.re),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: hdl/btil_node_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Holds the trie node pool. No dependencies.
module btil_node_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 21
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

FILE: hdl/btil_walker.sv
// Key walker of the binary trie core: sequencer that walks the key one bit at a
// time through the node memory (one read per existing node, a parent link update
// and a node clear per allocated node), allocates nodes and forms the result item.
// Depends on btil_pkg and btil_if.
module btil_walker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 match_mode_i,
  btil_req_if.sink             req_i,
  btil_rsp_if.source           rsp_o,
  output btil_pkg::ram_req_t   ram_req_o,
  input  btil_pkg::node_rec_t  ram_rdata_i
);
  import btil_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_ZERO,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic              fresh_q, fresh_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic              lookup_q, lookup_d;
  logic [FREE_W-1:0] nfree_q, nfree_d;
  node_rec_t         root_q, root_d;
  logic              res_found_q, res_found_d;
  logic              res_full_q, res_full_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic              rsp_found_q, rsp_found_d;
  logic              rsp_full_q, rsp_full_d;

  logic              accept;
  logic [LEN_W-1:0]  len_sat;
  node_rec_t         cur_rec;
  node_rec_t         upd_rec;
  node_rec_t         end_rec;
  logic [LEN_W-1:0]  cnt_m1;
  logic [POS_W-1:0]  pos;
  logic              c;
  logic [NODE_W-1:0] nx;
  logic              pool_out;
  logic              slot_free;

  assign req_i.ready     = (state_q == S_IDLE);
  assign accept          = req_i.valid && req_i.ready;
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.found     = rsp_found_q;
  assign rsp_o.pool_full = rsp_full_q;
  assign slot_free       = !rsp_valid_q || rsp_o.ready;

  // Saturate the key length
  assign len_sat = (req_i.key_length > LEN_W'(MAX_KEY_BITS)) ?
                   LEN_W'(MAX_KEY_BITS) : req_i.key_length;

  // Current node record: root registers, a fresh (all zero) node, or memory
  always_comb begin
    if (node_q == '0) begin
      cur_rec = root_q;
    end else if (fresh_q) begin
      cur_rec = '0;
    end else begin
      cur_rec = ram_rdata_i;
    end
  end

  // Key character for this step and the child link it selects
  assign cnt_m1   = cnt_q - LEN_W'(1);
  assign pos      = cnt_m1[POS_W-1:0];
  assign c        = key_q[pos];
  assign nx       = cur_rec.links[c];
  assign pool_out = (nfree_q == FREE_W'(NODE_COUNT));

  always_comb begin
    upd_rec          = cur_rec;
    upd_rec.links[c] = nfree_q[NODE_W-1:0];
    end_rec          = cur_rec;
    end_rec.end_mark = 1'b1;
  end

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    node_d      = node_q;
    fresh_d     = fresh_q;
    cnt_d       = cnt_q;
    key_d       = key_q;
    lookup_d    = lookup_q;
    nfree_d     = nfree_q;
    root_d      = root_q;
    res_found_d = res_found_q;
    res_full_d  = res_full_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_found_d = rsp_found_q;
    rsp_full_d  = rsp_full_q;
    ram_req_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          node_d      = '0;
          fresh_d     = 1'b0;
          cnt_d       = len_sat;
          key_d       = req_i.key_bits;
          lookup_d    = (req_i.req_type == REQ_LOOKUP);
          res_found_d = 1'b0;
          res_full_d  = 1'b0;
          state_d     = S_STEP;
        end
      end

      S_STEP: begin
        if (cnt_q == '0) begin
          // End of key: report or set the end mark
          if (lookup_q) begin
            res_found_d = (match_mode_i == MODE_EXACT) ? cur_rec.end_mark : 1'b1;
          end else if (node_q == '0) begin
            root_d.end_mark = 1'b1;
          end else begin
            ram_req_o.we    = 1'b1;
            ram_req_o.addr  = node_q;
            ram_req_o.wdata = end_rec;
          end
          state_d = S_DONE;
        end else if (nx != '0) begin
          // Follow an existing child; its record arrives next cycle
          ram_req_o.re   = 1'b1;
          ram_req_o.addr = nx;
          node_d         = nx;
          fresh_d        = 1'b0;
          cnt_d          = cnt_m1;
        end else if (lookup_q) begin
          state_d = S_DONE;
        end else if (pool_out) begin
          res_full_d = 1'b1;
          state_d    = S_DONE;
        end else begin
          // Allocate: link the parent to the next free node
          if (node_q == '0) begin
            root_d.links[c] = nfree_q[NODE_W-1:0];
          end else begin
            ram_req_o.we    = 1'b1;
            ram_req_o.addr  = node_q;
            ram_req_o.wdata = upd_rec;
          end
          node_d  = nfree_q[NODE_W-1:0];
          fresh_d = 1'b1;
          nfree_d = nfree_q + FREE_W'(1);
          cnt_d   = cnt_m1;
          state_d = S_ZERO;
        end
      end

      S_ZERO: begin
        // Clear the freshly allocated node
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = node_q;
        ram_req_o.wdata = '0;
        state_d         = S_STEP;
      end

      S_DONE: begin
        if (slot_free) begin
          rsp_valid_d = 1'b1;
          rsp_found_d = res_found_q;
          rsp_full_d  = res_full_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      node_q      <= '0;
      fresh_q     <= 1'b0;
      cnt_q       <= '0;
      key_q       <= '0;
      lookup_q    <= 1'b0;
      nfree_q     <= FREE_W'(1);
      root_q      <= '0;
      res_found_q <= 1'b0;
      res_full_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      rsp_found_q <= 1'b0;
      rsp_full_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      node_q      <= node_d;
      fresh_q     <= fresh_d;
      cnt_q       <= cnt_d;
      key_q       <= key_d;
      lookup_q    <= lookup_d;
      nfree_q     <= nfree_d;
      root_q      <= root_d;
      res_found_q <= res_found_d;
      res_full_q  <= res_full_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_found_q <= rsp_found_d;
      rsp_full_q  <= rsp_full_d;
    end
  end

  // Checks
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nfree_q >= FREE_W'(1)) && (nfree_q <= FREE_W'(NODE_COUNT)))
    else $error("free node counter out of range");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req_o.we && ram_req_o.re))
    else $error("read and write to node memory in one cycle");

  a_no_root_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req_o.we || ram_req_o.re) |-> (ram_req_o.addr != '0))
    else $error("node memory access to the root slot");

  a_rsp_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !(rsp_found_q && rsp_full_q))
    else $error("found and pool_full both set");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_STEP))
    else $error("accepted item did not start a walk");

endmodule
